@@ src/oflt_pkg.sv @@
// ---------------------------------------------------------------------------
// oflt_pkg
// Shared types and codes for the outstanding frame latency tracker.
// ---------------------------------------------------------------------------
package oflt_pkg;

	// Event kinds carried on the request channel
	localparam logic [1:0] KIND_FRAME_START = 2'd0;
	localparam logic [1:0] KIND_FRAME_END   = 2'd1;
	localparam logic [1:0] KIND_STREAM_END  = 2'd2;

	localparam int unsigned WINDOW_BITS  = 8;
	localparam logic [7:0]  WINDOW_RESET = 8'd16;
	localparam int unsigned SKIP_BITS    = 9;
	localparam int unsigned EVT_TIME_BITS = 48;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_CLEAR_PTR,
		DP_APPEND,
		DP_SEARCH,
		DP_COMPACT,
		DP_CLOSE,
		DP_MISS,
		DP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_end;
		logic is_stream_end;
		logic table_empty;
		logic last_entry;
		logic hit_now;
		logic out_busy;
	} dp_status_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_APPEND,
		ST_SRCH_RD,
		ST_SRCH_EV,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_CLOSE,
		ST_MISS,
		ST_RESULT
	} ctrl_state_t;

endpackage

@@ src/oflt_evt_if.sv @@
// ---------------------------------------------------------------------------
// oflt_evt_if
// Request channel carrying one tracker event.
// ---------------------------------------------------------------------------
interface oflt_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  stream_id;
	logic [63:0] frame_stamp;
	logic [47:0] event_time;

	modport source (output valid, kind, stream_id, frame_stamp, event_time, input ready);
	modport sink   (input valid, kind, stream_id, frame_stamp, event_time, output ready);
endinterface

@@ src/oflt_res_if.sv @@
// ---------------------------------------------------------------------------
// oflt_res_if
// Result channel carrying one tracker report per request.
// ---------------------------------------------------------------------------
interface oflt_res_if;
	logic        valid;
	logic        ready;
	logic        matched;
	logic [47:0] latency;
	logic [6:0]  dropped_now;
	logic [6:0]  ongoing_total;
	logic [31:0] completed_total;
	logic [31:0] dropped_total;
	logic        overflow;

	modport source (output valid, matched, latency, dropped_now, ongoing_total,
		completed_total, dropped_total, overflow, input ready);
	modport sink   (input valid, matched, latency, dropped_now, ongoing_total,
		completed_total, dropped_total, overflow, output ready);
endinterface

@@ src/oflt_ctrl.sv @@
// ---------------------------------------------------------------------------
// oflt_ctrl
// Sequencer: steps the datapath through append, search and compaction sweeps.
// ---------------------------------------------------------------------------
module oflt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  evt_valid,
	output logic                  evt_ready,
	input  oflt_pkg::dp_status_t  status,
	output oflt_pkg::dp_cmd_t     cmd
);

	oflt_pkg::ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oflt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command
	always_comb begin
		state_d   = state_q;
		cmd.op    = oflt_pkg::DP_NOP;
		evt_ready = 1'b0;
		unique case (state_q)
			oflt_pkg::ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					cmd.op  = oflt_pkg::DP_CAPTURE;
					state_d = oflt_pkg::ST_DISPATCH;
				end
			end
			oflt_pkg::ST_DISPATCH: begin
				cmd.op = oflt_pkg::DP_CLEAR_PTR;
				if (status.is_start) begin
					state_d = oflt_pkg::ST_APPEND;
				end else if (status.is_end) begin
					state_d = status.table_empty ? oflt_pkg::ST_MISS : oflt_pkg::ST_SRCH_RD;
				end else if (status.is_stream_end) begin
					state_d = status.table_empty ? oflt_pkg::ST_RESULT : oflt_pkg::ST_CMP_RD;
				end else begin
					state_d = oflt_pkg::ST_RESULT;
				end
			end
			oflt_pkg::ST_APPEND: begin
				cmd.op  = oflt_pkg::DP_APPEND;
				state_d = oflt_pkg::ST_RESULT;
			end
			oflt_pkg::ST_SRCH_RD: begin
				state_d = oflt_pkg::ST_SRCH_EV;
			end
			oflt_pkg::ST_SRCH_EV: begin
				cmd.op = oflt_pkg::DP_SEARCH;
				if (status.hit_now) begin
					state_d = oflt_pkg::ST_CMP_RD;
				end else if (status.last_entry) begin
					state_d = oflt_pkg::ST_MISS;
				end else begin
					state_d = oflt_pkg::ST_SRCH_RD;
				end
			end
			oflt_pkg::ST_CMP_RD: begin
				state_d = oflt_pkg::ST_CMP_EV;
			end
			oflt_pkg::ST_CMP_EV: begin
				cmd.op  = oflt_pkg::DP_COMPACT;
				state_d = status.last_entry ? oflt_pkg::ST_CLOSE : oflt_pkg::ST_CMP_RD;
			end
			oflt_pkg::ST_CLOSE: begin
				cmd.op  = oflt_pkg::DP_CLOSE;
				state_d = oflt_pkg::ST_RESULT;
			end
			oflt_pkg::ST_MISS: begin
				cmd.op  = oflt_pkg::DP_MISS;
				state_d = oflt_pkg::ST_RESULT;
			end
			oflt_pkg::ST_RESULT: begin
				// hold until the output register is free
				if (!status.out_busy) begin
					cmd.op  = oflt_pkg::DP_RESULT;
					state_d = oflt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = oflt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/oflt_datapath.sv @@
// ---------------------------------------------------------------------------
// oflt_datapath
// Record table memories, sweep pointers, counters and result register.
// ---------------------------------------------------------------------------
module oflt_datapath #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned NUM_STREAMS = 16,
	parameter int unsigned TIME_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic [1:0]            kind,
	input  logic [3:0]            stream_id,
	input  logic [63:0]           frame_stamp,
	input  logic [47:0]           event_time,
	input  logic                  res_ready,
	output logic                  res_valid,
	output logic                  res_matched,
	output logic [47:0]           res_latency,
	output logic [6:0]            res_dropped_now,
	output logic [6:0]            res_ongoing_total,
	output logic [31:0]           res_completed_total,
	output logic [31:0]           res_dropped_total,
	output logic                  res_overflow,
	input  oflt_pkg::dp_cmd_t     cmd,
	output oflt_pkg::dp_status_t  status
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned TW = (TIME_BITS < 48) ? TIME_BITS : 48;

	// Record table
	logic [3:0]                       mem_stream [TABLE_DEPTH];
	logic [63:0]                      mem_stamp  [TABLE_DEPTH];
	logic [TW-1:0]                    mem_start  [TABLE_DEPTH];
	logic [oflt_pkg::SKIP_BITS-1:0]   mem_skips  [TABLE_DEPTH];

	logic [3:0]                       rd_stream_q;
	logic [63:0]                      rd_stamp_q;
	logic [TW-1:0]                    rd_start_q;
	logic [oflt_pkg::SKIP_BITS-1:0]   rd_skips_q;

	// Captured event
	logic [1:0]    kind_q;
	logic          sid_ok_q;
	logic [3:0]    sid_q;
	logic [63:0]   stamp_q;
	logic [TW-1:0] tnow_q;

	// Sweep state and counters
	logic [CW-1:0] cnt_q, r_q, w_q, hit_q, dnow_q;
	logic          found_q, ovf_q;
	logic [47:0]   lat_q;
	logic [31:0]   completed_q, dropped_q;
	logic [7:0]    window_q;

	// Compaction decision for the entry under the read pointer
	logic [oflt_pkg::SKIP_BITS-1:0] skips_inc;
	logic [oflt_pkg::SKIP_BITS-1:0] skips_new;
	logic                           same_sid;
	logic                           keep;
	logic                           drop_cnt;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;

	assign same_sid  = (rd_stream_q == sid_q);
	assign skips_inc = (rd_skips_q == '1) ? rd_skips_q : rd_skips_q + 1'b1;

	always_comb begin
		skips_new = rd_skips_q;
		keep      = 1'b1;
		drop_cnt  = 1'b0;
		if (kind_q == oflt_pkg::KIND_STREAM_END) begin
			if (same_sid) begin
				keep     = 1'b0;
				drop_cnt = 1'b1;
			end
		end else if (r_q == hit_q) begin
			keep = 1'b0;
		end else if ((r_q < hit_q) && same_sid) begin
			skips_new = skips_inc;
			if (skips_inc > {1'b0, window_q}) begin
				keep     = 1'b0;
				drop_cnt = 1'b1;
			end
		end
	end

	assign wr_en   = ((cmd.op == oflt_pkg::DP_APPEND) && (cnt_q != CW'(TABLE_DEPTH)))
		|| ((cmd.op == oflt_pkg::DP_COMPACT) && keep);
	assign wr_addr = (cmd.op == oflt_pkg::DP_APPEND) ? cnt_q[AW-1:0] : w_q[AW-1:0];

	// Table write and registered read at the read pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (cmd.op == oflt_pkg::DP_APPEND) begin
				mem_stream[wr_addr] <= sid_q;
				mem_stamp[wr_addr]  <= stamp_q;
				mem_start[wr_addr]  <= tnow_q;
				mem_skips[wr_addr]  <= '0;
			end else begin
				mem_stream[wr_addr] <= rd_stream_q;
				mem_stamp[wr_addr]  <= rd_stamp_q;
				mem_start[wr_addr]  <= rd_start_q;
				mem_skips[wr_addr]  <= skips_new;
			end
		end
		rd_stream_q <= mem_stream[r_q[AW-1:0]];
		rd_stamp_q  <= mem_stamp[r_q[AW-1:0]];
		rd_start_q  <= mem_start[r_q[AW-1:0]];
		rd_skips_q  <= mem_skips[r_q[AW-1:0]];
	end

	// Event capture
	always_ff @(posedge clk) begin
		if (cmd.op == oflt_pkg::DP_CAPTURE) begin
			kind_q   <= kind;
			sid_q    <= stream_id;
			sid_ok_q <= ({5'd0, stream_id} < 9'(NUM_STREAMS));
			stamp_q  <= frame_stamp;
			tnow_q   <= event_time[TW-1:0];
		end
	end

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= oflt_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Pointers, counters and per-event flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			r_q         <= '0;
			w_q         <= '0;
			hit_q       <= '0;
			dnow_q      <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			lat_q       <= '0;
			completed_q <= '0;
			dropped_q   <= '0;
		end else begin
			case (cmd.op)
				oflt_pkg::DP_CAPTURE: begin
					found_q <= 1'b0;
					ovf_q   <= 1'b0;
					lat_q   <= '0;
					dnow_q  <= '0;
				end
				oflt_pkg::DP_CLEAR_PTR: begin
					r_q   <= '0;
					w_q   <= '0;
					hit_q <= CW'(TABLE_DEPTH);
				end
				oflt_pkg::DP_APPEND: begin
					if (cnt_q == CW'(TABLE_DEPTH)) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				oflt_pkg::DP_SEARCH: begin
					if (status.hit_now) begin
						found_q <= 1'b1;
						hit_q   <= r_q;
						lat_q   <= 48'(TW'(tnow_q - rd_start_q));
						r_q     <= '0;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end
				oflt_pkg::DP_COMPACT: begin
					r_q <= r_q + 1'b1;
					if (keep) begin
						w_q <= w_q + 1'b1;
					end
					if (drop_cnt) begin
						dnow_q <= dnow_q + 1'b1;
					end
				end
				oflt_pkg::DP_CLOSE: begin
					cnt_q     <= w_q;
					dropped_q <= dropped_q + 32'(dnow_q);
					if (kind_q == oflt_pkg::KIND_FRAME_END) begin
						completed_q <= completed_q + 1'b1;
					end
				end
				oflt_pkg::DP_MISS: begin
					completed_q <= completed_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.op == oflt_pkg::DP_RESULT) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == oflt_pkg::DP_RESULT) begin
			res_matched         <= found_q;
			res_latency         <= lat_q;
			res_dropped_now     <= 7'(dnow_q);
			res_ongoing_total   <= 7'(cnt_q);
			res_completed_total <= completed_q;
			res_dropped_total   <= dropped_q;
			res_overflow        <= ovf_q;
		end
	end

	// Status to the controller
	assign status.is_start      = sid_ok_q && (kind_q == oflt_pkg::KIND_FRAME_START);
	assign status.is_end        = sid_ok_q && (kind_q == oflt_pkg::KIND_FRAME_END);
	assign status.is_stream_end = sid_ok_q && (kind_q == oflt_pkg::KIND_STREAM_END);
	assign status.table_empty   = (cnt_q == '0);
	assign status.last_entry    = ((r_q + 1'b1) == cnt_q);
	assign status.hit_now       = same_sid && (rd_stamp_q == stamp_q);
	assign status.out_busy      = res_valid && !res_ready;

endmodule

@@ src/outstanding_frame_latency_tracker_core.sv @@
// ---------------------------------------------------------------------------
// outstanding_frame_latency_tracker_core
// Shared table of open frame start records, tagged by stream, with latency reporting.
// ---------------------------------------------------------------------------
// Usage:
//   evt carries one request: frame start, frame end or stream end, with the
//   stream, frame stamp and event time. res returns exactly one report per
//   request: match flag, latency, drops and the running totals.
//   cfg_we/cfg_wdata write the drop window; write it only while idle.
// Steps:
//   frame start: capture, dispatch, append, then result.
//   ignored kinds, stream end on an empty table: capture, dispatch, result.
//   frame end: a search sweep reads each record up to the match, then a
//   compaction sweep covers every outstanding record, then close and
//   result; a miss scans every record and skips compaction.
//   stream end: a compaction sweep over every outstanding record, close, result.
//   Each request is served by these sweeps over the record table; one
//   request is in work at a time.
// Reset: the table is empty, all counts are zero, the window is 16.
// Stall: a finished report waits in the output register; the next request
//   is taken meanwhile and its report holds until the register frees.
// ---------------------------------------------------------------------------
module outstanding_frame_latency_tracker_core #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned NUM_STREAMS = 16,
	parameter int unsigned TIME_BITS   = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	oflt_evt_if.sink    evt,
	oflt_res_if.source  res
);

	oflt_pkg::dp_cmd_t    cmd;
	oflt_pkg::dp_status_t status;

	oflt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.status    (status),
		.cmd       (cmd)
	);

	oflt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NUM_STREAMS (NUM_STREAMS),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.kind                (evt.kind),
		.stream_id           (evt.stream_id),
		.frame_stamp         (evt.frame_stamp),
		.event_time          (evt.event_time),
		.res_ready           (res.ready),
		.res_valid           (res.valid),
		.res_matched         (res.matched),
		.res_latency         (res.latency),
		.res_dropped_now     (res.dropped_now),
		.res_ongoing_total   (res.ongoing_total),
		.res_completed_total (res.completed_total),
		.res_dropped_total   (res.dropped_total),
		.res_overflow        (res.overflow),
		.cmd                 (cmd),
		.status              (status)
	);

endmodule

@@ sim/oflt_tb_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oflt_tb_if
// Testbench-side constants for the frame latency tracker bench.
// ---------------------------------------------------------------------------
// Holds the bench limits used by the checker and the top.
package oflt_tb_pkg;
	localparam int unsigned TB_TABLE_DEPTH = 64;
	localparam int unsigned TB_NUM_STREAMS = 16;
	localparam int unsigned IDLE_LIMIT     = 20000;

	// Unused kind code, sent to check that it is ignored
	localparam logic [1:0]  KIND_RESERVED  = 2'd3;
endpackage

@@ sim/oflt_latency_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oflt_latency_checker
// Predicts each tracker report from accepted requests and compares them.
// ---------------------------------------------------------------------------
module oflt_latency_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	oflt_evt_if         evt,
	oflt_res_if         res,
	output int          fail_count,
	output int          pending_reports,
	output int          report_count
);

	typedef struct packed {
		logic        matched;
		logic [47:0] latency;
		logic [6:0]  dropped_now;
		logic [6:0]  ongoing_total;
		logic [31:0] completed_total;
		logic [31:0] dropped_total;
		logic        overflow;
	} report_t;

	typedef struct packed {
		logic [3:0]  stream;
		logic [63:0] stamp;
		logic [47:0] start;
		logic [8:0]  skips;
	} record_t;

	record_t     open_frames[$];
	report_t     expected_reports[$];
	logic [31:0] completed_cnt;
	logic [31:0] dropped_cnt;
	logic [7:0]  drop_window;

	// Apply one request to the open frame table and build its report
	function automatic report_t track_event(logic [1:0] kind, logic [3:0] sid,
		logic [63:0] stamp, logic [47:0] tnow);
		report_t  r;
		record_t  rec;
		record_t  kept[$];
		int       hit;
		int       ndrop;
		r = '0;
		hit = -1;
		ndrop = 0;
		if (kind == oflt_pkg::KIND_FRAME_START) begin
			if (open_frames.size() < oflt_tb_pkg::TB_TABLE_DEPTH) begin
				rec.stream = sid;
				rec.stamp = stamp;
				rec.start = tnow;
				rec.skips = '0;
				open_frames.push_back(rec);
			end else begin
				r.overflow = 1'b1;
			end
		end else if (kind == oflt_pkg::KIND_FRAME_END) begin
			foreach (open_frames[i])
				if (hit < 0 && open_frames[i].stream == sid && open_frames[i].stamp == stamp)
					hit = i;
			if (hit >= 0) begin
				r.matched = 1'b1;
				r.latency = tnow - open_frames[hit].start;
				// age older records of the stream, drop those past the window
				foreach (open_frames[i]) begin
					rec = open_frames[i];
					if (i < hit && rec.stream == sid) begin
						if (rec.skips < 9'd511)
							rec.skips++;
						if (rec.skips > {1'b0, drop_window}) begin
							ndrop++;
							continue;
						end
					end
					if (i != hit)
						kept.push_back(rec);
				end
				open_frames = kept;
			end
			completed_cnt++;
		end else if (kind == oflt_pkg::KIND_STREAM_END) begin
			foreach (open_frames[i]) begin
				if (open_frames[i].stream == sid)
					ndrop++;
				else
					kept.push_back(open_frames[i]);
			end
			open_frames = kept;
		end
		dropped_cnt += 32'(ndrop);
		r.dropped_now = ndrop[6:0];
		r.ongoing_total = 7'(open_frames.size());
		r.completed_total = completed_cnt;
		r.dropped_total = dropped_cnt;
		return r;
	endfunction

	assign pending_reports = expected_reports.size();

	// Predict on request, compare on report
	always @(posedge clk or negedge arst_n) begin
		report_t want;
		report_t got;
		if (!arst_n) begin
			open_frames.delete();
			expected_reports.delete();
			completed_cnt = '0;
			dropped_cnt = '0;
			drop_window = oflt_pkg::WINDOW_RESET;
			fail_count = 0;
			report_count = 0;
		end else begin
			if (cfg_we)
				drop_window = cfg_wdata;
			if (evt.valid && evt.ready)
				expected_reports.push_back(track_event(evt.kind, evt.stream_id,
					evt.frame_stamp, evt.event_time));
			if (res.valid && res.ready) begin
				got = '{res.matched, res.latency, res.dropped_now, res.ongoing_total,
					res.completed_total, res.dropped_total, res.overflow};
				report_count++;
				if (expected_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected report %p", $realtime, got);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t report mismatch\n  exp %p\n  act %p",
								$realtime, want, got);
					end
				end
			end
		end
	end

endmodule

@@ sim/tb_outstanding_frame_latency_tracker_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_outstanding_frame_latency_tracker_core
// Drives frame start, frame end and stream end requests with random gaps and
// back-pressure across several drop windows; a checker predicts each report.
// ---------------------------------------------------------------------------
module tb_outstanding_frame_latency_tracker_core;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	int         fail_count;
	int         pending_reports;
	int         report_count;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         recv_hold = 0;
	int         idle_cycles = 0;
	int         sent = 0;

	// recent start stamps per stream, used to build matching frame ends
	logic [63:0] open_stamps[oflt_tb_pkg::TB_NUM_STREAMS][$];

	oflt_evt_if evt ();
	oflt_res_if res ();

	outstanding_frame_latency_tracker_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt.sink),
		.res       (res.source)
	);

	oflt_latency_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.evt             (evt),
		.res             (res),
		.fail_count      (fail_count),
		.pending_reports (pending_reports),
		.report_count    (report_count)
	);

	always #10 clk = ~clk;

	initial begin
		evt.valid = 1'b0;
		evt.kind = oflt_pkg::KIND_FRAME_START;
		evt.stream_id = '0;
		evt.frame_stamp = '0;
		evt.event_time = '0;
		res.ready = 1'b0;
	end

	// Receiver: random stalls, plus long holds on request
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			res.ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((evt.valid && evt.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > oflt_tb_pkg::IDLE_LIMIT) begin
			$display("timeout after %0d quiet cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// Offer one request and hold it until accepted; valid stays high after
	// acceptance so that the next request can follow without a gap
	task automatic send_request(logic [1:0] kind, logic [3:0] sid,
		logic [63:0] stamp, logic [47:0] tnow);
		if ($urandom_range(99) < send_idle_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		evt.valid <= 1'b1;
		evt.kind <= kind;
		evt.stream_id <= sid;
		evt.frame_stamp <= stamp;
		evt.event_time <= tnow;
		do @(posedge clk); while (!evt.ready);
		sent++;
		if (kind == oflt_pkg::KIND_FRAME_START)
			open_stamps[sid].push_back(stamp);
		else if (kind == oflt_pkg::KIND_STREAM_END)
			open_stamps[sid].delete();
	endtask

	// Drop valid and wait for every report
	task automatic drain_and_settle();
		evt.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_window(logic [7:0] value);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand_wide();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [47:0] rand_time();
		return 48'(rand_wide());
	endfunction

	// Mostly well-formed traffic: starts, ends matching open stamps, some noise
	task automatic random_burst(int count, int nstreams);
		logic [3:0]  sid;
		logic [63:0] stamp;
		int          pick;
		int          idx;
		repeat (count) begin
			sid = 4'($urandom_range(nstreams - 1));
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_request(oflt_pkg::KIND_FRAME_START, sid, rand_wide(), rand_time());
			end else if (pick < 85 && open_stamps[sid].size() > 0) begin
				// usually the newest few, so older ones age and drop
				idx = open_stamps[sid].size() - 1 - $urandom_range(
					open_stamps[sid].size() > 3 ? 3 : open_stamps[sid].size() - 1);
				stamp = open_stamps[sid][idx];
				open_stamps[sid].delete(idx);
				send_request(oflt_pkg::KIND_FRAME_END, sid, stamp, rand_time());
			end else if (pick < 92) begin
				send_request(oflt_pkg::KIND_FRAME_END, sid, rand_wide(), rand_time());
			end else if (pick < 97) begin
				send_request(oflt_pkg::KIND_STREAM_END, sid, '0, rand_time());
			end else begin
				send_request(oflt_tb_pkg::KIND_RESERVED, sid, rand_wide(), rand_time());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every kind, unmatched end, empty stream end
		send_request(oflt_pkg::KIND_FRAME_START, 4'd0, '0, '0);
		send_request(oflt_pkg::KIND_FRAME_START, 4'd15, '1, '1);
		send_request(oflt_pkg::KIND_FRAME_END, 4'd15, '1, '0);
		send_request(oflt_pkg::KIND_FRAME_END, 4'd0, '0, '1);
		send_request(oflt_pkg::KIND_FRAME_END, 4'd3, 64'h1234, 48'h5);
		send_request(oflt_pkg::KIND_STREAM_END, 4'd7, '0, '0);
		send_request(oflt_tb_pkg::KIND_RESERVED, 4'd15, '1, '1);
		send_request(oflt_pkg::KIND_FRAME_START, 4'd2, 64'hA, 48'd100);
		send_request(oflt_pkg::KIND_FRAME_START, 4'd2, 64'hB, 48'd200);
		send_request(oflt_pkg::KIND_FRAME_START, 4'd2, 64'hA, 48'd300);
		send_request(oflt_pkg::KIND_FRAME_END, 4'd2, 64'hB, 48'd50);
		send_request(oflt_pkg::KIND_STREAM_END, 4'd2, '1, '1);

		// Window 0: any skip drops; fill the table to overflow too
		write_window(8'd0);
		recv_hold = 400;
		repeat (66) send_request(oflt_pkg::KIND_FRAME_START, 4'($urandom_range(15)),
			rand_wide(), rand_time());
		drain_and_settle();
		for (int s = 0; s < 16; s++)
			send_request(oflt_pkg::KIND_STREAM_END, 4'(s), '0, '0);

		send_idle_pct = 25;
		recv_idle_pct = 75;
		random_burst(550, 2);
		write_window(8'd255);
		random_burst(150, 16);
		send_idle_pct = 75;
		recv_idle_pct = 25;
		write_window(8'd2);
		random_burst(500, 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_window(8'd5);
		random_burst(450, 16);

		drain_and_settle();
		$display("covered %0d requests, %0d reports, windows 16/0/255/2/5, overflow",
			sent, report_count);
		if (fail_count == 0 && pending_reports == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/oflt_pkg.sv
src/oflt_evt_if.sv
src/oflt_res_if.sv
src/oflt_ctrl.sv
src/oflt_datapath.sv
src/outstanding_frame_latency_tracker_core.sv
sim/oflt_tb_if.sv
sim/oflt_latency_checker.sv
sim/tb_outstanding_frame_latency_tracker_core.sv
